/* rtl/tsss_pkg.sv */
// ----------------------------------------------------------------------------
// tsss_pkg
// Shared types and constants of the thermal stage step sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsss_pkg;

  // item kinds, carried on in_tuser
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_ADVANCE = 2'd2,
    KIND_REPORT  = 2'd3
  } kind_t;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_STEP_COUNT  = 3'd0;
  localparam logic [2:0] REG_CYCLE_TOTAL = 3'd1;
  localparam logic [2:0] REG_AD_ON       = 3'd2;
  localparam logic [2:0] REG_AD_START    = 3'd3;
  localparam logic [2:0] REG_TEMP_FLOOR  = 3'd4;
  localparam logic [2:0] REG_TEMP_CEIL   = 3'd5;

  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int IN_DW    = 64;
  localparam int IN_UW    = 2;
  localparam int OUT_DW   = 48;

  localparam int SCNT_W   = 5;
  localparam int CTOT_W   = 10;
  localparam int TEMP_W   = 14;
  localparam int TDLT_W   = 12;
  localparam int HOLD_W   = 16;
  localparam int HDLT_W   = 13;
  localparam int CYC_W    = 11;
  localparam int OPOS_W   = 4;

  localparam logic [CYC_W-1:0]  CYC_MAX        = 11'd2047;
  localparam logic [CYC_W-1:0]  CYC_FIRST      = 11'd1;
  localparam logic [TEMP_W-1:0] TEMP_CEIL_RST  = 14'd12000;

  // one stored step
  typedef struct packed {
    logic signed [HDLT_W-1:0] hdelta;
    logic        [HOLD_W-1:0] hold;
    logic signed [TDLT_W-1:0] tdelta;
    logic        [TEMP_W-1:0] temp;
  } entry_t;

endpackage

/* rtl/thermal_stage_step_sequencer_top.sv */
// ----------------------------------------------------------------------------
// thermal_stage_step_sequencer_top
// Throughput: one item per cycle unless out_tready stalls; an accepted item
// moves through three register stages (table read, multiply, add and clamp)
// with per-stage ready, so bubbles fill while out_tready is low.
// Reset: synchronous rst_n puts the stage on step 0, cycle 1 and the registers
// at their reset values; table entries stay undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module thermal_stage_step_sequencer_top #(
  parameter int MAX_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tsss_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [tsss_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [tsss_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  // input items
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // entry_index[3:0], entry_temperature[17:4], entry_temp_delta[29:18],
  // entry_hold[45:30], entry_hold_delta[58:46], zero fill [63:59]
  input  logic [tsss_pkg::IN_DW-1:0]    in_tdata,
  // kind[1:0]
  input  logic [tsss_pkg::IN_UW-1:0]    in_tuser,
  // result items
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // step_valid[0], step_position[4:1], cycle_number[15:5],
  // target_temperature[29:16], target_hold[45:30], more_steps[46], zero [47]
  output logic [tsss_pkg::OUT_DW-1:0]   out_tdata
);

  import tsss_pkg::*;

  // position runs 0..MAX_STEPS (a position at the step count or above meaning finished)
  localparam int POS_W = $clog2(MAX_STEPS + 1);
  localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CNT_W = (POS_W > SCNT_W) ? POS_W : SCNT_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STEPS);
  localparam int TP_W  = TDLT_W + CYC_W + 1;
  localparam int HP_W  = HDLT_W + CYC_W + 1;
  localparam int SUM_W = 26;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [SCNT_W-1:0] step_count_r;
  logic [CTOT_W-1:0] cycle_total_r;
  logic              ad_on_r;
  logic [CTOT_W-1:0] ad_start_r;
  logic [TEMP_W-1:0] temp_floor_r;
  logic [TEMP_W-1:0] temp_ceil_r;

  logic       cfg_wr;
  logic [2:0] reg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r  <= SCNT_W'(1);
      cycle_total_r <= CTOT_W'(1);
      ad_on_r       <= 1'b0;
      ad_start_r    <= '0;
      temp_floor_r  <= '0;
      temp_ceil_r   <= TEMP_CEIL_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_STEP_COUNT:  step_count_r  <= cfg_pwdata[SCNT_W-1:0];
        REG_CYCLE_TOTAL: cycle_total_r <= cfg_pwdata[CTOT_W-1:0];
        REG_AD_ON:       ad_on_r       <= cfg_pwdata[0];
        REG_AD_START:    ad_start_r    <= cfg_pwdata[CTOT_W-1:0];
        REG_TEMP_FLOOR:  temp_floor_r  <= cfg_pwdata[TEMP_W-1:0];
        REG_TEMP_CEIL:   temp_ceil_r   <= cfg_pwdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STEP_COUNT:  cfg_prdata = CFG_DW'(step_count_r);
      REG_CYCLE_TOTAL: cfg_prdata = CFG_DW'(cycle_total_r);
      REG_AD_ON:       cfg_prdata = CFG_DW'(ad_on_r);
      REG_AD_START:    cfg_prdata = CFG_DW'(ad_start_r);
      REG_TEMP_FLOOR:  cfg_prdata = CFG_DW'(temp_floor_r);
      REG_TEMP_CEIL:   cfg_prdata = CFG_DW'(temp_ceil_r);
      default:         cfg_prdata = '0;
    endcase
  end

  // step count limited to the table depth
  logic [CNT_W-1:0] count;
  assign count = (CNT_W'(step_count_r) > MAX_CNT) ? MAX_CNT : CNT_W'(step_count_r);

  // --------------------------------------------------------------------------
  // Handshake: each stage moves when it is empty or the next one moves
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_rdy, s2_rdy, s1_rdy, acc;

  assign out_rdy   = !out_v_r || out_tready;
  assign s2_rdy    = !s2_v_r || out_rdy;
  assign s1_rdy    = !s1_v_r || s2_rdy;
  assign in_tready = s1_rdy;
  assign acc       = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;

  // --------------------------------------------------------------------------
  // Input decode and sequencer state update (on accept)
  // --------------------------------------------------------------------------
  kind_t             kind;
  logic [3:0]        in_idx;
  entry_t            in_entry;

  assign kind            = kind_t'(in_tuser);
  assign in_idx          = in_tdata[3:0];
  assign in_entry.temp   = in_tdata[17:4];
  assign in_entry.tdelta = in_tdata[29:18];
  assign in_entry.hold   = in_tdata[45:30];
  assign in_entry.hdelta = in_tdata[58:46];

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [CYC_W-1:0] cyc_r, cyc_nxt, cyc_inc;

  assign pos_inc = pos_r + 1'b1;
  assign cyc_inc = (cyc_r < CYC_MAX) ? cyc_r + 1'b1 : cyc_r;

  always_comb begin
    pos_nxt = pos_r;
    cyc_nxt = cyc_r;
    case (kind)
      KIND_RESTART: begin
        pos_nxt = '0;
        cyc_nxt = CYC_FIRST;
      end
      KIND_ADVANCE: begin
        if (CNT_W'(pos_r) < count) begin
          if (CNT_W'(pos_inc) >= count) begin
            // end of the step list: count a cycle, wrap if cycles remain
            cyc_nxt = cyc_inc;
            pos_nxt = (cyc_inc <= CYC_W'(cycle_total_r)) ? '0 : pos_inc;
          end else begin
            pos_nxt = pos_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cyc_r <= CYC_FIRST;
    end else if (acc) begin
      pos_r <= pos_nxt;
      cyc_r <= cyc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Step table: write on a load, registered read at the new position
  // --------------------------------------------------------------------------
  entry_t           step_mem [MAX_STEPS];
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx, rd_idx;

  assign wr_en  = (kind == KIND_LOAD) && (32'(in_idx) < MAX_STEPS);
  assign wr_idx = IDX_W'(in_idx);
  assign rd_idx = pos_nxt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (acc && wr_en) begin
      step_mem[wr_idx] <= in_entry;
    end
  end

  // stage 1: entry, position and cycle after the update
  entry_t           s1_ent_r;
  logic [POS_W-1:0] s1_pos_r;
  logic [CYC_W-1:0] s1_cyc_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      // write-first bypass when a load hits the current step
      s1_ent_r <= (wr_en && (wr_idx == rd_idx)) ? in_entry : step_mem[rd_idx];
      s1_pos_r <= pos_nxt;
      s1_cyc_r <= cyc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: validity, look-ahead flag, delta products
  // --------------------------------------------------------------------------
  logic                    valid_c, apply_c, more_c;
  logic [CYC_W-1:0]        elapsed_c;
  logic signed [CYC_W:0]   el_s_c;
  logic signed [TP_W-1:0]  tprod_c;
  logic signed [HP_W-1:0]  hprod_c;

  assign valid_c   = CNT_W'(s1_pos_r) < count;
  assign apply_c   = ad_on_r && (s1_cyc_r > CYC_W'(ad_start_r));
  assign elapsed_c = s1_cyc_r - CYC_W'(ad_start_r);
  assign el_s_c    = signed'({1'b0, elapsed_c});
  assign tprod_c   = s1_ent_r.tdelta * el_s_c;
  assign hprod_c   = s1_ent_r.hdelta * el_s_c;
  assign more_c    = (count != '0) &&
                     ((valid_c && ((CNT_W+1)'(s1_pos_r) + 1'b1 < (CNT_W+1)'(count))) ||
                      ((CYC_W+1)'(s1_cyc_r) + 1'b1 <= (CYC_W+1)'(cycle_total_r)));

  logic                   s2_valid_r, s2_apply_r, s2_more_r;
  logic [OPOS_W-1:0]      s2_pos_r;
  logic [CYC_W-1:0]       s2_cyc_r;
  logic [TEMP_W-1:0]      s2_temp_r;
  logic [HOLD_W-1:0]      s2_hold_r;
  logic signed [TP_W-1:0] s2_tprod_r;
  logic signed [HP_W-1:0] s2_hprod_r;

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_rdy) begin
      s2_valid_r <= valid_c;
      s2_apply_r <= apply_c;
      s2_more_r  <= more_c;
      s2_pos_r   <= valid_c ? OPOS_W'(s1_pos_r) : '0;
      s2_cyc_r   <= s1_cyc_r;
      s2_temp_r  <= s1_ent_r.temp;
      s2_hold_r  <= s1_ent_r.hold;
      s2_tprod_r <= tprod_c;
      s2_hprod_r <= hprod_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: add and clamp into the result register
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] t_sum_c, h_sum_c, t_floor_c, t_ceil_c;
  logic [TEMP_W-1:0]       t_res_c;
  logic [HOLD_W-1:0]       h_res_c;

  assign t_sum_c   = SUM_W'(signed'({1'b0, s2_temp_r})) + SUM_W'(s2_tprod_r);
  assign h_sum_c   = SUM_W'(signed'({1'b0, s2_hold_r})) + SUM_W'(s2_hprod_r);
  assign t_floor_c = SUM_W'(temp_floor_r);
  assign t_ceil_c  = SUM_W'(temp_ceil_r);

  always_comb begin
    t_res_c = s2_temp_r;
    h_res_c = s2_hold_r;
    if (s2_apply_r) begin
      // floor first: with a floor above the ceiling, sums below the floor take the floor, all others the ceiling
      if (t_sum_c < t_floor_c) begin
        t_res_c = temp_floor_r;
      end else if (t_sum_c > t_ceil_c) begin
        t_res_c = temp_ceil_r;
      end else begin
        t_res_c = t_sum_c[TEMP_W-1:0];
      end
      if (h_sum_c < 0) begin
        h_res_c = '0;
      end else if (h_sum_c > SUM_W'(65535)) begin
        h_res_c = '1;
      end else begin
        h_res_c = h_sum_c[HOLD_W-1:0];
      end
    end
    if (!s2_valid_r) begin
      t_res_c = '0;
      h_res_c = '0;
    end
  end

  logic              o_valid_r, o_more_r;
  logic [OPOS_W-1:0] o_pos_r;
  logic [CYC_W-1:0]  o_cyc_r;
  logic [TEMP_W-1:0] o_temp_r;
  logic [HOLD_W-1:0] o_hold_r;

  always_ff @(posedge clk) begin
    if (s2_v_r && out_rdy) begin
      o_valid_r <= s2_valid_r;
      o_more_r  <= s2_more_r;
      o_pos_r   <= s2_pos_r;
      o_cyc_r   <= s2_cyc_r;
      o_temp_r  <= t_res_c;
      o_hold_r  <= h_res_c;
    end
  end

  assign out_tdata = {1'b0, o_more_r, o_hold_r, o_temp_r, o_cyc_r, o_pos_r, o_valid_r};

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_tvalid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (out_rdy) begin
        out_v_r <= s2_v_r;
      end
    end
  end

endmodule
